[src/shamh_pkg.sv]
// Package: SHA-256 hasher constants, control struct and round functions.
`timescale 1ns / 1ps
`default_nettype none
package shamh_pkg;

    localparam int WORD_W  = 32;
    localparam int WORDS   = 16;
    localparam int ROUNDS  = 64;
    localparam int CHAIN_N = 8;

    // byte position where the 64-bit length field starts
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_IDX  = 3'd7;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [WORD_W-1:0] INIT_H [CHAIN_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic load_byte;   // write one message byte into the block buffer
        logic pad_first;   // 0x80, zeros, and length if it fits
        logic pad_second;  // extra block: zeros and length
        logic round_en;    // one compression round
        logic chain_add;   // fold working vars into chaining words
        logic chain_init;  // restart with initial hash values
    } shamh_ctrl_t;

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

[src/shamh_msg_if.sv]
// Interface: message byte channel (valid/ready plus byte payload).
`timescale 1ns / 1ps
`default_nettype none
interface shamh_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       is_last;

    modport source (output valid, output msg_byte, output byte_present, output is_last,
                    input ready);
    modport sink   (input valid, input msg_byte, input byte_present, input is_last,
                    output ready);
endinterface
`default_nettype wire

[src/shamh_digest_if.sv]
// Interface: digest word channel (valid/ready plus digest payload).
`timescale 1ns / 1ps
`default_nettype none
interface shamh_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface
`default_nettype wire

[src/shamh_sched.sv]
// Block buffer and message schedule window: byte loading, padding, W expansion.
`timescale 1ns / 1ps
`default_nettype none
module shamh_sched (
    input  logic                      clk,
    input  shamh_pkg::shamh_ctrl_t    ctrl,
    input  logic [7:0]                msg_byte,
    input  logic [5:0]                fill,
    input  logic [63:0]               bit_len,
    output logic [shamh_pkg::WORD_W-1:0] w_cur
);

    logic [shamh_pkg::WORD_W-1:0] w_reg  [shamh_pkg::WORDS];
    logic [shamh_pkg::WORD_W-1:0] w_next [shamh_pkg::WORDS];
    logic [shamh_pkg::WORD_W-1:0] w_new;
    logic [1:0]                   lane;

    assign w_cur = w_reg[0];
    assign lane  = 2'd3 - fill[1:0];

    // W[t] = s1(W[t-2]) + W[t-7] + s0(W[t-15]) + W[t-16], window slides down
    assign w_new = shamh_pkg::small_sigma1(w_reg[14]) + w_reg[9]
                 + shamh_pkg::small_sigma0(w_reg[1]) + w_reg[0];

    always_comb
    begin
        w_next = w_reg;
        if (ctrl.load_byte)
        begin
            w_next[fill[5:2]][{lane, 3'b000} +: 8] = msg_byte;
        end
        else if (ctrl.pad_first)
        begin
            for (int j = 0; j < shamh_pkg::WORDS; j++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (6'(4 * j + k) == fill)
                    begin
                        w_next[j][31 - 8 * k -: 8] = shamh_pkg::PAD_BYTE;
                    end
                    else if (6'(4 * j + k) > fill)
                    begin
                        w_next[j][31 - 8 * k -: 8] = 8'h00;
                    end
                end
            end
            if (fill < shamh_pkg::LEN_POS)
            begin
                w_next[14] = bit_len[63:32];
                w_next[15] = bit_len[31:0];
            end
        end
        else if (ctrl.pad_second)
        begin
            for (int j = 0; j < shamh_pkg::WORDS - 2; j++)
            begin
                w_next[j] = '0;
            end
            w_next[14] = bit_len[63:32];
            w_next[15] = bit_len[31:0];
        end
        else if (ctrl.round_en)
        begin
            for (int j = 0; j < shamh_pkg::WORDS - 1; j++)
            begin
                w_next[j] = w_reg[j + 1];
            end
            w_next[15] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

endmodule
`default_nettype wire

[src/shamh_round.sv]
// Shared SHA-256 round unit with working variables and chaining words.
`timescale 1ns / 1ps
`default_nettype none
module shamh_round (
    input  logic                         clk,
    input  logic                         rst_n,
    input  shamh_pkg::shamh_ctrl_t       ctrl,
    input  logic [5:0]                   round_idx,
    input  logic [shamh_pkg::WORD_W-1:0] w_cur,
    input  logic [2:0]                   word_sel,
    output logic [shamh_pkg::WORD_W-1:0] chain_word
);

    logic [shamh_pkg::WORD_W-1:0] chain_reg  [shamh_pkg::CHAIN_N];
    logic [shamh_pkg::WORD_W-1:0] chain_next [shamh_pkg::CHAIN_N];
    logic [shamh_pkg::WORD_W-1:0] v_reg      [shamh_pkg::CHAIN_N];
    logic [shamh_pkg::WORD_W-1:0] v_next     [shamh_pkg::CHAIN_N];
    logic [shamh_pkg::WORD_W-1:0] t1;
    logic [shamh_pkg::WORD_W-1:0] t2;
    logic [shamh_pkg::WORD_W-1:0] ch;
    logic [shamh_pkg::WORD_W-1:0] maj;

    assign chain_word = chain_reg[word_sel];

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + shamh_pkg::big_sigma1(v_reg[4]) + ch
               + shamh_pkg::ROUND_K[round_idx] + w_cur;
    assign t2  = shamh_pkg::big_sigma0(v_reg[0]) + maj;

    // working vars always reload from the new chain words, so they are
    // ready for the next block with no separate load step
    always_comb
    begin
        chain_next = chain_reg;
        v_next     = v_reg;
        if (ctrl.chain_init)
        begin
            chain_next = shamh_pkg::INIT_H;
            v_next     = shamh_pkg::INIT_H;
        end
        else if (ctrl.chain_add)
        begin
            for (int i = 0; i < shamh_pkg::CHAIN_N; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
            v_next = chain_next;
        end
        else if (ctrl.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= shamh_pkg::INIT_H;
            v_reg     <= shamh_pkg::INIT_H;
        end
        else
        begin
            chain_reg <= chain_next;
            v_reg     <= v_next;
        end
    end

endmodule
`default_nettype wire

[src/sha256_message_hasher_unit.sv]
// Top level: SHA-256 hasher fed one byte per transaction, emits eight digest words.
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 hasher. Each msg transaction carries at most one byte (byte_present)
// and may end the message (is_last). A byte that does not complete a 64-byte
// block is just written into the block buffer. The 64th byte of a block starts
// the compression: one round per cycle on a single shared round unit, 64 rounds
// and then a fold into the chaining words, after which msg is ready again.
// On is_last the block is padded and compressed, with one more zero-and-length
// block when 56 to 63 bytes were pending (and after the full block is first
// compressed when the last byte itself completes one), then offers the eight
// digest words H0..H7 on the digest channel, one per cycle while digest.ready
// is high, last_word marking H7. After H7 is taken the hasher restarts for the
// next message. The bit length counts modulo 2^64. The msg channel is not
// ready while a block compresses, and after an is_last transaction it stays
// low until the last digest word is taken.
module sha256_message_hasher_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    shamh_msg_if.sink             msg,
    shamh_digest_if.source        digest
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD1  = 3'd1;
    localparam logic [2:0] S_PAD2  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  after_reg, after_next;   // where to go once a block is folded in
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;

    logic                   msg_accept;
    logic                   out_accept;
    shamh_pkg::shamh_ctrl_t ctrl;
    logic [31:0]            w_cur;
    logic [31:0]            chain_word;

    assign msg.ready  = (state_reg == S_IDLE);
    assign msg_accept = msg.valid && msg.ready;

    assign digest.valid       = (state_reg == S_OUT);
    assign digest.digest_word = chain_word;
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == shamh_pkg::LAST_IDX);
    assign out_accept         = digest.valid && digest.ready;

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        ctrl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (msg_accept)
                begin
                    if (msg.byte_present)
                    begin
                        ctrl.load_byte = 1'b1;
                        bits_next      = bits_reg + shamh_pkg::BITS_PER_BYTE;
                        fill_next      = fill_reg + 6'd1;   // wraps to 0 on a full block
                    end
                    if (msg.byte_present && fill_reg == shamh_pkg::LAST_FILL)
                    begin
                        state_next = S_ROUND;
                        round_next = '0;
                        after_next = msg.is_last ? S_PAD1 : S_IDLE;
                    end
                    else if (msg.is_last)
                    begin
                        state_next = S_PAD1;
                    end
                end
            end
            S_PAD1:
            begin
                ctrl.pad_first = 1'b1;
                state_next     = S_ROUND;
                round_next     = '0;
                after_next     = (fill_reg < shamh_pkg::LEN_POS) ? S_OUT : S_PAD2;
            end
            S_PAD2:
            begin
                ctrl.pad_second = 1'b1;
                state_next      = S_ROUND;
                round_next      = '0;
                after_next      = S_OUT;
            end
            S_ROUND:
            begin
                ctrl.round_en = 1'b1;
                round_next    = round_reg + 6'd1;
                if (round_reg == shamh_pkg::LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                ctrl.chain_add = 1'b1;
                state_next     = after_reg;
                idx_next       = '0;
            end
            S_OUT:
            begin
                if (out_accept)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == shamh_pkg::LAST_IDX)
                    begin
                        ctrl.chain_init = 1'b1;
                        fill_next       = '0;
                        bits_next       = '0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    shamh_sched u_sched (
        .clk      (clk),
        .ctrl     (ctrl),
        .msg_byte (msg.msg_byte),
        .fill     (fill_reg),
        .bit_len  (bits_reg),
        .w_cur    (w_cur)
    );

    shamh_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .round_idx  (round_reg),
        .w_cur      (w_cur),
        .word_sel   (idx_reg),
        .chain_word (chain_word)
    );

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for sha256_message_hasher_unit: byte stream in, digest words checked.
`timescale 1ns / 1ps

// Directed messages first: empty, "abc", tail with no byte, single bytes.
// Then random messages: lengths cluster near the 56 and 64 byte padding
// boundaries, with a few multi-block ones. Ignored empty steps are mixed in
// as noise. A bit-exact SHA-256 model runs on every accepted msg transaction.
// Each digest transaction is checked against the oldest predicted word.
module tb_top;

    localparam int RUN_LIMIT   = 300000;   // cycles before we call it hung
    localparam int SETTLE_CYC  = 200;      // > two compressions plus the digest burst
    localparam int RAND_ITEMS  = 170;
    localparam int MIN_RAND_MSG = 6;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT    = 11;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    // one msg transaction plus driver hints (hints never reach the bus)
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       is_last;
        logic       drain;      // hold off until every digest word is back
        logic       calm;       // no idling on either side while this runs
    } feed_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_exp_t;

    logic clk = 1'b0;
    logic rst_n;

    shamh_msg_if    msg_ch ();
    shamh_digest_if dig_ch ();

    sha256_message_hasher_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    feed_item_t  feed_queue [$];
    digest_exp_t digest_due [$];
    feed_item_t  next_item;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] bit_len;

    int  cycle_count = 0;
    int  bad_count   = 0;
    int  rand_items  = 0;      // every msg transaction queued so far
    int  rand_msgs   = 0;
    logic msg_took   = 1'b0;   // msg transaction at the last rising edge
    logic calm_now   = 1'b0;
    logic drv_calm   = 1'b0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk into chain_h
    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++)
        begin
            s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < 8; i++)
            chain_h[i] = H_START[i];
        fill    = '0;
        bit_len = '0;
    endfunction

    // absorb one accepted transaction; on a last one, pad and queue the digest
    function automatic void sha_absorb(input logic [7:0] b, input logic present,
                                       input logic last);
        int idx;
        digest_exp_t e;
        if (present)
        begin
            blk[fill] = b;
            bit_len   = bit_len + 64'd8;
            if (fill == 6'd63)
            begin
                sha_compress();
                fill = '0;
            end
            else
                fill = fill + 6'd1;
        end
        if (last)
        begin
            idx = fill;
            blk[idx] = PAD_MARK;
            idx++;
            // no room for the length field: spill into an extra block
            if (idx > 56)
            begin
                while (idx < 64)
                begin
                    blk[idx] = 8'h00;
                    idx++;
                end
                sha_compress();
                idx = 0;
            end
            while (idx < 56)
            begin
                blk[idx] = 8'h00;
                idx++;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = bit_len[63 - 8*i -: 8];
            sha_compress();
            for (int i = 0; i < 8; i++)
            begin
                e.word = chain_h[i];
                e.idx  = i[2:0];
                e.last = (i == 7);
                digest_due.push_back(e);
            end
            sha_restart();
        end
    endfunction

    task automatic note_failure(input string what);
        bad_count++;
        if (bad_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic add_item(input logic [7:0] b, input logic present, input logic last,
                            input logic drain, input logic calm);
        feed_item_t it;
        it.msg_byte     = b;
        it.byte_present = present;
        it.is_last      = last;
        it.drain        = drain;
        it.calm         = calm;
        feed_queue.push_back(it);
        rand_items++;
    endtask

    // random message of len bytes; sometimes ends on an empty tail transaction
    task automatic queue_message(input int len, input logic drain, input logic calm);
        logic tail;
        logic hold;
        tail = (len == 0) || ($urandom_range(3) == 0);
        hold = drain;
        for (int k = 0; k < len; k++)
        begin
            // ignored empty step as noise
            if ($urandom_range(7) == 0)
            begin
                add_item(8'($urandom), 1'b0, 1'b0, hold, calm);
                hold = 1'b0;
            end
            add_item(8'($urandom), 1'b1, (k == len - 1) && !tail, hold, calm);
            hold = 1'b0;
        end
        if (tail)
            add_item(8'($urandom), 1'b0, 1'b1, hold, calm);
    endtask

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int len;
        int pick;
        rst_n               = 1'b0;
        msg_ch.valid        = 1'b0;
        msg_ch.msg_byte     = 8'h00;
        msg_ch.byte_present = 1'b0;
        msg_ch.is_last      = 1'b0;
        dig_ch.ready        = 1'b0;
        sha_restart();
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;

        // directed part
        add_item(8'h5a, 1'b0, 1'b0, 1'b0, 1'b0);      // empty step, ignored
        add_item(8'hff, 1'b0, 1'b1, 1'b0, 1'b0);      // empty message
        add_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);      // "abc"
        add_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b0);      // wait for "abc" digest first
        add_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'hc3, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(8'h3c, 1'b0, 1'b1, 1'b0, 1'b0);      // empty tail ends message
        add_item(8'hff, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h80, 1'b1, 1'b1, 1'b1, 1'b0);

        // random part: boundary lengths dominate, a few span several blocks
        while (rand_items < RAND_ITEMS || rand_msgs < MIN_RAND_MSG)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                len = $urandom_range(0, 10);
            else if (pick < 7)
                len = $urandom_range(52, 66);
            else if (pick < 8)
                len = $urandom_range(118, 130);
            else
                len = $urandom_range(11, 51);
            // the first message is the long idle-free stretch
            if (rand_msgs == 0)
                len = $urandom_range(52, 66);
            // keep the total transaction count near the budget
            if (rand_items + len > RAND_ITEMS)
                len = (rand_items < RAND_ITEMS) ? RAND_ITEMS - rand_items : 0;
            // messages 0 and 1 run with no idling at all
            queue_message(len, $urandom_range(3) == 0, rand_msgs == 0 || rand_msgs == 1);
            rand_msgs++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (feed_queue.size() != 0 || msg_ch.valid)
            @(posedge clk);
        while (digest_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (bad_count == 0 && digest_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: msg source, updates on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            msg_ch.valid <= 1'b0;
        else if (!msg_ch.valid || msg_took)
        begin
            // drain items wait for the digest of everything before them
            if (feed_queue.size() == 0
                || (feed_queue[0].drain && digest_due.size() != 0)
                || (!feed_queue[0].calm && $urandom_range(99) < IDLE_PCT))
                msg_ch.valid <= 1'b0;
            else
            begin
                next_item = feed_queue.pop_front();
                msg_ch.msg_byte     <= next_item.msg_byte;
                msg_ch.byte_present <= next_item.byte_present;
                msg_ch.is_last      <= next_item.is_last;
                drv_calm            <= next_item.calm;
                msg_ch.valid        <= 1'b1;
            end
        end
    end

    // digest sink backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            dig_ch.ready <= 1'b0;
        else
            dig_ch.ready <= calm_now || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_exp_t exp_w;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > RUN_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d digest words outstanding",
                         cycle_count, digest_due.size());
                $display("simulation failed");
                $finish;
            end
            else
            begin
                msg_took = msg_ch.valid && msg_ch.ready;
                if (msg_took)
                begin
                    calm_now = drv_calm;
                    sha_absorb(msg_ch.msg_byte, msg_ch.byte_present, msg_ch.is_last);
                end
                if (dig_ch.valid && dig_ch.ready)
                begin
                    if (digest_due.size() == 0)
                        note_failure($sformatf("unexpected digest word %08h idx %0d last %0b",
                                     dig_ch.digest_word, dig_ch.word_index,
                                     dig_ch.last_word));
                    else
                    begin
                        exp_w = digest_due.pop_front();
                        if (dig_ch.digest_word !== exp_w.word
                            || dig_ch.word_index !== exp_w.idx
                            || dig_ch.last_word !== exp_w.last)
                            note_failure($sformatf(
                                "word exp %08h/%0d/%0b got %08h/%0d/%0b",
                                exp_w.word, exp_w.idx, exp_w.last,
                                dig_ch.digest_word, dig_ch.word_index,
                                dig_ch.last_word));
                    end
                end
            end
        end
    end

endmodule
